/* src/lom_pkg.sv */
// ----------------------------------------------------------------------------
// lom_pkg
// shared types and codes of the limit order matcher
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int IDX_W = 6;

    typedef enum logic [2:0] {
        ST_RESTED    = 3'd0,
        ST_DONE      = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        K_LIMIT  = 2'd0,
        K_MARKET = 2'd1,
        K_IOC    = 2'd2,
        K_IOC3   = 2'd3
    } t_kind;

    localparam logic REQ_NEW    = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT
    } t_state;

    typedef enum logic [1:0] {
        WR_FILL,
        WR_KILL,
        WR_LOAD
    } t_wr_op;

    typedef struct packed {
        logic             en;
        t_wr_op           op;
        logic [IDX_W-1:0] idx;
        logic             side;
        logic [31:0]      price;
        logic [31:0]      qty;
        logic [31:0]      ident;
        logic [31:0]      stamp;
    } t_wr;

    typedef struct packed {
        logic             live;
        logic             hit;
        logic [31:0]      price;
        logic [31:0]      age;
        logic [31:0]      qty;
        logic [31:0]      ident;
        logic [IDX_W-1:0] idx;
        logic             id_hit;
        logic [IDX_W-1:0] id_idx;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
    } t_tok;

endpackage

/* src/limit_order_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_matcher
// bounded price-time priority order book built as a chain of slot cells
// ----------------------------------------------------------------------------
// channel | dir | handshake          | word
// request | in  | i_valid / o_stall  | req_type, order_id, side, kind, price, qty
// result  | out | o_valid / i_stall  | item_kind, ids, price, qty, status, last
//
// a search word runs through the register of each of the ORDER_SLOTS cells in turn
// a request takes (fills + 1) searches; its status word leaves after the last one
// synchronous active-low reset empties the book at once
// a waiting result word holds the sequencer; the next request waits for idle
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic [1:0]  i_order_kind,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_quantity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_item_kind,
    output logic [31:0] o_buyer_id,
    output logic [31:0] o_seller_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_qty,
    output logic [2:0]  o_status,
    output logic        o_last
);

    t_state      r_state, n_state;
    logic        r_req;
    logic [31:0] r_id;
    logic        r_side;
    t_kind       r_kind;
    logic [31:0] r_limit;
    logic [31:0] r_qty, n_qty;
    logic [31:0] r_ctr, n_ctr;
    logic        r_start, n_start;
    t_tok        r_res;
    t_tok        tok [ORDER_SLOTS+1];
    t_wr         wr;
    logic        r_ov, n_ov;
    logic        r_okind, n_okind;
    logic [31:0] r_obuy, n_obuy, r_osell, n_osell, r_oprice, n_oprice, r_oqty, n_oqty;
    t_status     r_ostat, n_ostat;
    logic        accept, out_free, price_ok, market, fill_go;
    logic [31:0] fill;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign market   = r_kind == K_MARKET;
    assign price_ok = market || ((r_side == SIDE_BUY) ? (r_res.price <= r_limit)
                                                      : (r_res.price >= r_limit));
    assign fill     = (r_qty < r_res.qty) ? r_qty : r_res.qty;
    assign fill_go  = r_qty != 32'd0 && r_res.hit && price_ok;

    always_comb begin
        tok[0]      = '0;
        tok[0].live = r_start;
    end

    for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
        lom_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[g]),
            .i_side (r_side),
            .i_ctr  (r_ctr),
            .i_id   (r_id),
            .i_wr   (wr),
            .o_tok  (tok[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_SCAN;
            S_SCAN: if (tok[ORDER_SLOTS].live) n_state = S_ACT;
            S_ACT: begin
                if (out_free) n_state = (r_req == REQ_NEW && fill_go) ? S_SCAN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        n_start  = 1'b0;
        n_qty    = r_qty;
        n_ctr    = r_ctr;
        wr       = '0;
        wr.side  = r_side;
        wr.price = r_limit;
        wr.ident = r_id;
        wr.stamp = r_ctr;
        wr.qty   = r_qty;
        n_ov     = r_ov && i_stall;
        n_okind  = r_okind;
        n_obuy   = r_obuy;
        n_osell  = r_osell;
        n_oprice = r_oprice;
        n_oqty   = r_oqty;
        n_ostat  = r_ostat;
        priority if (r_state == S_IDLE && accept) begin
            n_start = 1'b1;
            n_qty   = i_quantity;
        end else if (r_state == S_ACT && out_free) begin
            n_ov     = 1'b1;
            n_okind  = 1'b1;
            n_obuy   = '0;
            n_osell  = '0;
            n_oprice = '0;
            n_oqty   = '0;
            if (r_req == REQ_CANCEL) begin
                n_ostat = r_res.id_hit ? ST_CANCELLED : ST_NOT_FOUND;
                wr.en   = r_res.id_hit;
                wr.op   = WR_KILL;
                wr.idx  = r_res.id_idx;
            end else if (fill_go) begin
                n_okind  = 1'b0;
                n_obuy   = (r_side == SIDE_BUY) ? r_id : r_res.ident;
                n_osell  = (r_side == SIDE_BUY) ? r_res.ident : r_id;
                n_oprice = r_res.price;
                n_oqty   = fill;
                n_ostat  = ST_RESTED;
                n_qty    = r_qty - fill;
                n_start  = 1'b1;
                wr.en    = 1'b1;
                wr.op    = WR_FILL;
                wr.idx   = r_res.idx;
                wr.qty   = fill;
            end else if (r_qty == 32'd0) begin
                n_ostat = ST_DONE;
            end else if (r_kind != K_LIMIT) begin
                n_ostat = ST_DROPPED;
            end else if (r_res.free_hit) begin
                n_ostat = ST_RESTED;
                wr.en   = 1'b1;
                wr.op   = WR_LOAD;
                wr.idx  = r_res.free_idx;
                n_ctr   = r_ctr + 32'd1;
            end else begin
                n_ostat = ST_FULL;
            end
        end else begin
            n_start = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_ctr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_ctr   <= n_ctr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_id    <= i_order_id;
            r_side  <= i_side;
            r_kind  <= t_kind'(i_order_kind);
            r_limit <= i_limit_price;
        end
        if (r_state == S_SCAN && tok[ORDER_SLOTS].live) r_res <= tok[ORDER_SLOTS];
        r_qty    <= n_qty;
        r_okind  <= n_okind;
        r_obuy   <= n_obuy;
        r_osell  <= n_osell;
        r_oprice <= n_oprice;
        r_oqty   <= n_oqty;
        r_ostat  <= n_ostat;
    end

    assign o_stall       = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid       = r_ov && i_rst_n;
    assign o_item_kind   = r_okind;
    assign o_buyer_id    = r_obuy;
    assign o_seller_id   = r_osell;
    assign o_trade_price = r_oprice;
    assign o_trade_qty   = r_oqty;
    assign o_status      = r_ostat;
    assign o_last        = r_okind;

endmodule

/* src/lom_cell.sv */
// ----------------------------------------------------------------------------
// lom_cell
// one book slot; merges its order into the passing search word
// ----------------------------------------------------------------------------
module lom_cell
    import lom_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tok        i_tok,
    input  logic        i_side,
    input  logic [31:0] i_ctr,
    input  logic [31:0] i_id,
    input  t_wr         i_wr,
    output t_tok        o_tok
);

    logic        r_valid;
    logic        r_side;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic [31:0] r_ident;
    logic [31:0] r_stamp;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [31:0] age;
    logic        better;
    logic        sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && i_wr.idx == IDX_W'(IDX)) begin
            unique case (i_wr.op)
                WR_FILL: begin
                    r_qty <= r_qty - i_wr.qty;
                    if (r_qty == i_wr.qty) r_valid <= 1'b0;
                end
                WR_KILL: r_valid <= 1'b0;
                WR_LOAD: begin
                    r_valid <= 1'b1;
                    r_side  <= i_wr.side;
                    r_price <= i_wr.price;
                    r_qty   <= i_wr.qty;
                    r_ident <= i_wr.ident;
                    r_stamp <= i_wr.stamp;
                end
                default: r_valid <= r_valid;
            endcase
        end
    end

    always_comb begin
        age    = i_ctr - r_stamp;
        better = (i_side == SIDE_BUY) ? (r_price < i_tok.price) : (r_price > i_tok.price);
        sel    = r_valid && r_side != i_side &&
                 (!i_tok.hit || better || (r_price == i_tok.price && age > i_tok.age));
        n_tok  = i_tok;
        if (sel) begin
            n_tok.hit   = 1'b1;
            n_tok.price = r_price;
            n_tok.age   = age;
            n_tok.qty   = r_qty;
            n_tok.ident = r_ident;
            n_tok.idx   = IDX_W'(IDX);
        end
        if (!i_tok.id_hit && r_valid && r_ident == i_id) begin
            n_tok.id_hit = 1'b1;
            n_tok.id_idx = IDX_W'(IDX);
        end
        if (!i_tok.free_hit && !r_valid) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = IDX_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/lom_checker.sv */
// ----------------------------------------------------------------------------
// lom_checker
// port-level checks of the limit order matcher
// ----------------------------------------------------------------------------
module lom_checker
    import lom_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_item_kind,
    input logic [31:0] o_trade_qty,
    input logic [2:0]  o_status,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_trade_qty))
        else $error("stalled result word changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without going busy");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last == o_item_kind)
        else $error("last flag not on status word");

    a_trade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item_kind |-> o_status == ST_RESTED && o_trade_qty != 32'd0)
        else $error("bad trade word");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_item_kind(o_item_kind),
    .o_trade_qty(o_trade_qty),
    .o_status   (o_status),
    .o_last     (o_last)
);

/* sim/tb_limit_order_matcher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_limit_order_matcher
// self-checking bench for the price-time priority order book
// a directed table, then random order flow with heavy book reuse; every
// result word is compared against a behavioral book kept in the bench
// ----------------------------------------------------------------------------
module tb_limit_order_matcher;
    import lom_pkg::*;

    localparam int SLOTS   = 32;
    localparam int N_RAND  = 318;

    typedef struct {
        logic        req;
        logic [31:0] id;
        logic        side;
        logic [1:0]  kind;
        logic [31:0] price;
        logic [31:0] qty;
        logic        chk;
        logic [2:0]  st;
    } t_row;

    typedef struct {
        logic        ik;
        logic [31:0] buyer;
        logic [31:0] seller;
        logic [31:0] price;
        logic [31:0] qty;
        logic [2:0]  st;
        logic        last;
    } t_res;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        out_stall;
    logic        out_valid;
    logic        req_type;
    logic [31:0] order_id;
    logic        side;
    logic [1:0]  order_kind;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic        r_ik;
    logic [31:0] r_buyer;
    logic [31:0] r_seller;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic [2:0]  r_st;
    logic        r_last;

    logic        bk_valid [SLOTS];
    logic        bk_side  [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_qty   [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic [31:0] bk_stamp [SLOTS];
    logic [31:0] arrivals;

    t_res expected_words[$];
    t_row dir_rows[$];
    logic [31:0] id_pool[$];
    int   errors;
    int   mismatches;
    int   n_words;
    int   n_trades;
    bit   stim_done;
    bit   hold_long;

    limit_order_matcher #(.ORDER_SLOTS(SLOTS)) u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(out_stall),
        .i_req_type(req_type), .i_order_id(order_id), .i_side(side),
        .i_order_kind(order_kind), .i_limit_price(limit_price),
        .i_quantity(quantity), .o_valid(out_valid), .i_stall(in_stall),
        .o_item_kind(r_ik), .o_buyer_id(r_buyer), .o_seller_id(r_seller),
        .o_trade_price(r_price), .o_trade_qty(r_qty), .o_status(r_st),
        .o_last(r_last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("[limit_order_matcher] ERROR");
        $finish;
    end

    function automatic t_res status_word(logic [2:0] st);
        t_res w;
        w = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, st, 1'b1};
        return w;
    endfunction

    function automatic void add_word(t_res w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic int best_resting(logic s);
        int best;
        logic bp;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (bk_valid[i] && bk_side[i] != s) begin
                if (best < 0) begin
                    best = i;
                end else begin
                    bp = (s == SIDE_BUY) ? (bk_price[i] < bk_price[best])
                                         : (bk_price[i] > bk_price[best]);
                    if (bp || (bk_price[i] == bk_price[best] &&
                        (arrivals - bk_stamp[i]) > (arrivals - bk_stamp[best])))
                        best = i;
                end
            end
        end
        return best;
    endfunction

    task automatic predict_match(t_row r);
        logic [31:0] q;
        logic [31:0] fill;
        logic [2:0]  st;
        int b;
        int f;
        t_res w;
        q = r.qty;
        if (r.req == REQ_CANCEL) begin
            st = ST_NOT_FOUND;
            for (int i = 0; i < SLOTS; i++) begin
                if (st == ST_NOT_FOUND && bk_valid[i] && bk_id[i] == r.id) begin
                    bk_valid[i] = 1'b0;
                    st = ST_CANCELLED;
                end
            end
            add_word(status_word(st));
            return;
        end
        while (q != 0) begin
            b = best_resting(r.side);
            if (b < 0) break;
            if (r.kind != K_MARKET) begin
                if (r.side == SIDE_BUY && bk_price[b] > r.price) break;
                if (r.side != SIDE_BUY && bk_price[b] < r.price) break;
            end
            fill = (q < bk_qty[b]) ? q : bk_qty[b];
            w.ik = 1'b0;
            w.buyer = (r.side == SIDE_BUY) ? r.id : bk_id[b];
            w.seller = (r.side == SIDE_BUY) ? bk_id[b] : r.id;
            w.price = bk_price[b];
            w.qty = fill;
            w.st = ST_RESTED;
            w.last = 1'b0;
            add_word(w);
            n_trades++;
            q -= fill;
            bk_qty[b] -= fill;
            if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
        end
        if (q == 0) begin
            st = ST_DONE;
        end else if (r.kind != K_LIMIT) begin
            st = ST_DROPPED;
        end else begin
            f = -1;
            for (int i = 0; i < SLOTS; i++)
                if (f < 0 && !bk_valid[i]) f = i;
            if (f < 0) begin
                st = ST_FULL;
            end else begin
                bk_valid[f] = 1'b1;
                bk_side[f] = r.side;
                bk_price[f] = r.price;
                bk_qty[f] = q;
                bk_id[f] = r.id;
                bk_stamp[f] = arrivals;
                arrivals++;
                st = ST_RESTED;
            end
        end
        add_word(status_word(st));
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_order(t_row r);
        int n_idle;
        n_idle = $urandom_range(0, 11);
        repeat (n_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.req;
        order_id <= r.id;
        side <= r.side;
        order_kind <= r.kind;
        limit_price <= r.price;
        quantity <= r.qty;
        @(posedge clk);
        while (out_stall) @(posedge clk);
        predict_match(r);
        if (r.chk && expected_words[$].st != r.st) begin
            errors++;
            if (mismatches < 10)
                $display("directed row id %0h: table status %0d, book gives %0d",
                         r.id, r.st, expected_words[$].st);
            mismatches++;
        end
        @(negedge clk);
    endtask

    function automatic t_row rand_order();
        t_row r;
        int sel;
        r.chk = 1'b0;
        r.st = ST_RESTED;
        sel = $urandom_range(0, 99);
        r.req = (sel < 15) ? REQ_CANCEL : REQ_NEW;
        if (r.req == REQ_CANCEL && id_pool.size() > 0 && sel < 12)
            r.id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else
            r.id = $urandom();
        r.side = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        r.kind = (sel < 6) ? K_LIMIT : (sel < 8) ? K_MARKET : (sel < 9) ? K_IOC : K_IOC3;
        sel = $urandom_range(0, 19);
        r.price = (sel == 0) ? $urandom() : 32'd1000 + $urandom_range(0, 15);
        sel = $urandom_range(0, 19);
        r.qty = (sel == 0) ? $urandom() : (sel == 1) ? 32'd0 : $urandom_range(1, 40);
        if (r.req == REQ_NEW) begin
            id_pool.insert(id_pool.size(), r.id);
            if (id_pool.size() > 64) void'(id_pool.pop_front());
        end
        return r;
    endfunction

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_stall = 1'b0;
        req_type = 1'b0;
        order_id = '0;
        side = 1'b0;
        order_kind = K_LIMIT;
        limit_price = '0;
        quantity = '0;
        errors = 0;
        mismatches = 0;
        n_words = 0;
        n_trades = 0;
        stim_done = 1'b0;
        hold_long = 1'b0;
        arrivals = '0;
        for (int i = 0; i < SLOTS; i++) begin
            bk_valid[i] = 1'b0; bk_side[i] = 1'b0; bk_price[i] = '0;
            bk_qty[i] = '0; bk_id[i] = '0; bk_stamp[i] = '0;
        end
        // req, id, side, kind, price, qty, chk, status
        dir_rows = '{
            '{REQ_CANCEL, 32'h0, 1'b0, K_LIMIT, 32'h0, 32'h0, 1'b1, ST_NOT_FOUND},
            '{REQ_NEW, 32'h1, 1'b0, K_LIMIT, 32'h0, 32'h0, 1'b1, ST_DONE},
            '{REQ_NEW, 32'h2, 1'b0, K_MARKET, 32'h0, 32'h5, 1'b1, ST_DROPPED},
            '{REQ_NEW, 32'h3, 1'b1, K_IOC, 32'h10, 32'h5, 1'b1, ST_DROPPED},
            '{REQ_NEW, 32'h4, 1'b1, K_IOC3, 32'h10, 32'h5, 1'b1, ST_DROPPED},
            '{REQ_NEW, 32'hFFFFFFFF, 1'b1, K_LIMIT, 32'hFFFFFFFF, 32'hFFFFFFFF,
              1'b1, ST_RESTED},
            '{REQ_NEW, 32'h10, 1'b1, K_LIMIT, 32'd100, 32'd10, 1'b1, ST_RESTED},
            '{REQ_NEW, 32'h11, 1'b1, K_LIMIT, 32'd100, 32'd10, 1'b1, ST_RESTED},
            '{REQ_NEW, 32'h12, 1'b1, K_LIMIT, 32'd90, 32'd5, 1'b1, ST_RESTED},
            '{REQ_NEW, 32'h13, 1'b0, K_LIMIT, 32'd50, 32'd7, 1'b1, ST_RESTED},
            '{REQ_NEW, 32'h13, 1'b0, K_LIMIT, 32'd60, 32'd7, 1'b1, ST_RESTED},
            '{REQ_NEW, 32'h20, 1'b0, K_LIMIT, 32'd100, 32'd12, 1'b0, ST_DONE},
            '{REQ_NEW, 32'h21, 1'b0, K_IOC, 32'd100, 32'd20, 1'b0, ST_DROPPED},
            '{REQ_NEW, 32'h22, 1'b1, K_MARKET, 32'hFFFFFFFF, 32'd3, 1'b0, ST_DONE},
            '{REQ_CANCEL, 32'h13, 1'b0, K_LIMIT, 32'h0, 32'h0, 1'b1, ST_CANCELLED},
            '{REQ_CANCEL, 32'h13, 1'b1, K_LIMIT, 32'h0, 32'h0, 1'b0, ST_CANCELLED},
            '{REQ_NEW, 32'h23, 1'b0, K_MARKET, 32'h0, 32'hFFFFFFFF, 1'b0, ST_DONE},
            '{REQ_NEW, 32'h24, 1'b1, K_LIMIT, 32'h0, 32'd1, 1'b0, ST_RESTED}
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[k]) send_order(dir_rows[k]);
        // fill the book with non-crossing asks to reach the full case
        for (int k = 0; k < SLOTS + 2; k++)
            send_order('{REQ_NEW, 32'h100 + k, 1'b1, K_LIMIT, 32'd5000 + k, 32'd2,
                         1'b0, ST_RESTED});
        // sweep the whole book with one market buy
        send_order('{REQ_NEW, 32'h200, 1'b0, K_MARKET, 32'd0, 32'hFFFFFFFF,
                     1'b0, ST_RESTED});
        for (int k = 0; k < N_RAND; k++) begin
            if (k == N_RAND / 2) hold_long = 1'b1;
            send_order(rand_order());
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int n_wait;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_long) begin
                in_stall <= 1'b1;
                repeat (800) @(negedge clk);
                hold_long = 1'b0;
                in_stall <= 1'b0;
            end else begin
                n_wait = $urandom_range(0, 11);
                if (n_wait > 0) begin
                    in_stall <= 1'b1;
                    repeat (n_wait) @(negedge clk);
                    in_stall <= 1'b0;
                end
                // stay ready until one word goes through
                @(posedge clk);
                while (!(out_valid && !in_stall)) @(posedge clk);
            end
        end
    end

    initial begin
        t_res e;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !in_stall) begin
                n_words++;
                if (expected_words.size() == 0) begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected word kind %0d status %0d", r_ik, r_st);
                    mismatches++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.ik !== r_ik || e.buyer !== r_buyer || e.seller !== r_seller ||
                        e.price !== r_price || e.qty !== r_qty || e.st !== r_st ||
                        e.last !== r_last) begin
                        errors++;
                        if (mismatches < 10) begin
                            $display("mismatch expected %0d %h %h %0d %0d %0d %0d",
                                     e.ik, e.buyer, e.seller, e.price, e.qty, e.st,
                                     e.last);
                            $display("         actual   %0d %h %h %0d %0d %0d %0d",
                                     r_ik, r_buyer, r_seller, r_price, r_qty, r_st,
                                     r_last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_words.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d result words, %0d trades, directed table plus %0d random orders",
                 n_words, n_trades, N_RAND);
        $display("book full, market sweep, cancels and a long result hold-off included");
        if (errors == 0 && expected_words.size() == 0)
            $display("[limit_order_matcher] OK");
        else
            $display("[limit_order_matcher] ERROR");
        $finish;
    end

endmodule

/* limit_order_matcher.f */
src/lom_pkg.sv
src/lom_cell.sv
src/limit_order_matcher.sv
src/lom_checker.sv
sim/tb_limit_order_matcher.sv
